@@ rtl/core/adcr_pkg.sv @@
// Shared constants and helpers for the audio DMA chunk ring.
`timescale 1ns / 1ps
`default_nettype none

package adcr_pkg;

	localparam int CHUNK_LEN_DEF  = 64;
	localparam int NUM_CHUNKS_DEF = 16;

	localparam int FRAME_W   = 32;
	localparam int CHUNK_O_W = 4;
	localparam int FREE_W    = 12;
	localparam int COUNT_W   = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DONE  = 1'b1;

	typedef logic [FRAME_W-1:0] frame_t;

	function automatic frame_t swap_halves(input frame_t s);
		return {s[FRAME_W/2-1:0], s[FRAME_W-1:FRAME_W/2]};
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/audio_dma_chunk_ring.sv @@
// Audio DMA chunk ring: frame store, chunk pointers and DMA frame readout.
//
// Input channel (item_valid / item_stall) carries op and frame_in. A write
// (op 0) stores one frame, halves swapped, into the current write chunk
// unless the ring is full, and gives one result in the cycle after; writes
// sustain one transaction a cycle while the output is not stalled and no
// readout runs. A chunk-done (op 1) zeroes the retired chunk, advances the
// play and queue pointers and streams the CHUNK_LEN frames of the newly
// queued chunk, one a cycle while the output is not stalled, the last marked
// by last. Each frame passes through the registered read port of the frame
// store and then the output register; the next item is taken once the final
// frame has moved into the output register and the output is not stalled.
// Output channel (result_valid / result_stall): a stalled result holds; the
// store readout pauses with it and resumes without loss. The status fields
// reflect the pointers and counters after the item.
// Reset: the frame store is zeroed by a sweep over all NUM_CHUNKS * CHUNK_LEN
// entries (1024 at defaults), during which item_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module audio_dma_chunk_ring
	import adcr_pkg::*;
#(
	parameter int CHUNK_LEN  = CHUNK_LEN_DEF,
	parameter int NUM_CHUNKS = NUM_CHUNKS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic                 op,
	input  wire logic [FRAME_W-1:0]   frame_in,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      accepted,
	output logic [FRAME_W-1:0]        frame_out,
	output logic                      last,
	output logic [CHUNK_O_W-1:0]      queued_chunk,
	output logic [FREE_W-1:0]         free_bytes,
	output logic [COUNT_W-1:0]        underrun_count,
	output logic [COUNT_W-1:0]        frames_played
);

	localparam int DEPTH = NUM_CHUNKS * CHUNK_LEN;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(NUM_CHUNKS);
	localparam int OW    = $clog2(CHUNK_LEN);
	localparam int DCW   = $clog2(CHUNK_LEN + 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DUMP  = 2'd2;

	typedef logic [CW-1:0] chunk_t;
	typedef logic [AW-1:0] addr_t;

	function automatic addr_t chunk_addr(input chunk_t c, input logic [OW-1:0] o);
		return AW'(c) * AW'(CHUNK_LEN) + AW'(o);
	endfunction

	function automatic chunk_t next_chunk(input chunk_t c);
		return (c == CW'(NUM_CHUNKS - 1)) ? '0 : c + 1'b1;
	endfunction

	frame_t mem [DEPTH];

	logic [1:0]      state_q;
	addr_t           clr_cnt_q;
	logic [DCW-1:0]  dcnt_q;
	logic [OW-1:0]   woff_q;
	chunk_t          write_q;
	chunk_t          playing_q;
	chunk_t          queued_q;
	chunk_t          ret_q;
	logic [COUNT_W-1:0] played_q;
	logic [COUNT_W-1:0] underrun_q;

	logic            rd_vld_s1;
	logic            last_s1;
	frame_t          rd_data_s1;

	logic            out_vld_q;
	logic            acc_out_q;
	frame_t          frame_q;
	logic            last_q;

	logic            out_free;
	logic            acc;
	logic            full;
	logic            wr_store;
	logic            move;
	logic            issue;
	logic [OW-1:0]   didx;
	chunk_t          queued_nx;
	logic            mem_we;
	addr_t           mem_waddr;
	frame_t          mem_wdata;
	logic [CW:0]     free_chunks;

	assign out_free   = !out_vld_q || !result_stall;
	assign item_stall = !(state_q == ST_IDLE && out_free);
	assign acc        = item_valid && !item_stall;
	assign full       = (write_q == queued_q) || (write_q == playing_q);
	assign wr_store   = acc && (op == OP_WRITE) && !full;
	assign move       = rd_vld_s1 && out_free;
	assign didx       = dcnt_q[OW-1:0];
	assign issue      = (state_q == ST_DUMP) && (dcnt_q < DCW'(CHUNK_LEN))
	                    && (!rd_vld_s1 || move);
	assign queued_nx  = next_chunk(queued_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chunk_addr(ret_q, didx);
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
		end else if (wr_store) begin
			mem_we    = 1'b1;
			mem_waddr = chunk_addr(write_q, woff_q);
			mem_wdata = swap_halves(frame_in);
		end else if (issue) begin
			mem_we    = 1'b1;
		end
	end

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[chunk_addr(queued_q, didx)];
			last_s1    <= (dcnt_q == DCW'(CHUNK_LEN - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			dcnt_q     <= '0;
			woff_q     <= '0;
			write_q    <= CW'(NUM_CHUNKS - 1);
			playing_q  <= '0;
			queued_q   <= '0;
			ret_q      <= '0;
			played_q   <= '0;
			underrun_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (wr_store) begin
						if (woff_q == OW'(CHUNK_LEN - 1)) begin
							woff_q  <= '0;
							write_q <= next_chunk(write_q);
						end else begin
							woff_q <= woff_q + 1'b1;
						end
					end
					if (acc && op == OP_DONE) begin
						state_q   <= ST_DUMP;
						dcnt_q    <= '0;
						ret_q     <= playing_q;
						playing_q <= queued_q;
						queued_q  <= queued_nx;
						played_q  <= played_q + COUNT_W'(CHUNK_LEN);
						if (queued_nx == write_q) begin
							underrun_q <= underrun_q + 1'b1;
						end
					end
				end
				ST_DUMP: begin
					if (issue) begin
						dcnt_q    <= dcnt_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else if (move) begin
						rd_vld_s1 <= 1'b0;
					end
					if (move && last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (acc && op == OP_WRITE) begin
			out_vld_q <= 1'b1;
		end else if (move) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && op == OP_WRITE) begin
			acc_out_q <= !full;
			frame_q   <= '0;
			last_q    <= 1'b1;
		end else if (move) begin
			acc_out_q <= 1'b0;
			frame_q   <= rd_data_s1;
			last_q    <= last_s1;
		end
	end

	assign free_chunks = (playing_q >= write_q)
	                     ? (CW + 1)'(playing_q) - (CW + 1)'(write_q)
	                     : (CW + 1)'(playing_q) + (CW + 1)'(NUM_CHUNKS) - (CW + 1)'(write_q);

	assign result_valid   = out_vld_q;
	assign accepted       = acc_out_q;
	assign frame_out      = frame_q;
	assign last           = last_q;
	assign queued_chunk   = CHUNK_O_W'(queued_q);
	assign free_bytes     = FREE_W'(32'(free_chunks) * 32'(CHUNK_LEN * 4));
	assign underrun_count = underrun_q;
	assign frames_played  = played_q;

endmodule

`default_nettype wire

@@ sim/audio_dma_chunk_ring_test.sv @@
// Self-checking testbench for the audio DMA chunk ring: frame writes, chunk readout, counters.
`timescale 1ns / 1ps

module audio_dma_chunk_ring_test;
	import adcr_pkg::*;

	localparam int DIRECTED_ITEMS = 24;
	localparam int RANDOM_ITEMS   = 406;
	localparam int SETTLE_AT      = DIRECTED_ITEMS;
	localparam int HOLD_AT        = 120;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LO       = 200;
	localparam int QUIET_HI       = 300;
	localparam int IDLE_PCT       = 34;
	localparam int DRAIN_CYCLES   = 100;
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct {
		logic   op;
		frame_t frame;
	} host_item_t;

	typedef struct {
		logic                 accepted;
		frame_t               frame;
		logic                 last_beat;
		logic [CHUNK_O_W-1:0] queued;
		logic [FREE_W-1:0]    free;
		logic [COUNT_W-1:0]   underruns;
		logic [COUNT_W-1:0]   played;
	} ring_result_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 op           = OP_WRITE;
	frame_t               frame_in     = '0;
	logic                 result_stall = 1'b0;
	logic                 item_stall;
	logic                 result_valid;
	logic                 accepted;
	frame_t               frame_out;
	logic                 last;
	logic [CHUNK_O_W-1:0] queued_chunk;
	logic [FREE_W-1:0]    free_bytes;
	logic [COUNT_W-1:0]   underrun_count;
	logic [COUNT_W-1:0]   frames_played;

	// predicted ring state
	frame_t             ring_mem [NUM_CHUNKS_DEF][CHUNK_LEN_DEF];
	int                 wr_off     = 0;
	int                 wr_chunk   = NUM_CHUNKS_DEF - 1;
	int                 play_chunk = 0;
	int                 q_chunk    = 0;
	logic [COUNT_W-1:0] played     = '0;
	logic [COUNT_W-1:0] underruns  = '0;

	host_item_t   host_items[$];
	ring_result_t ring_outputs_due[$];
	host_item_t   next_item;
	ring_result_t want;
	int unsigned  sent        = 0;
	int unsigned  errors      = 0;
	int unsigned  cycles      = 0;
	int unsigned  hold_left   = 0;
	bit           hold_done   = 1'b0;
	bit           steady      = 1'b0;
	bit           item_taken  = 1'b0;

	audio_dma_chunk_ring DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.op             (op),
		.frame_in       (frame_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.accepted       (accepted),
		.frame_out      (frame_out),
		.last           (last),
		.queued_chunk   (queued_chunk),
		.free_bytes     (free_bytes),
		.underrun_count (underrun_count),
		.frames_played  (frames_played)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic ring_result_t ring_status(logic acc, frame_t f, logic lst);
		ring_result_t r;
		r.accepted  = acc;
		r.frame     = f;
		r.last_beat = lst;
		r.queued    = CHUNK_O_W'(q_chunk);
		r.free      = FREE_W'(((play_chunk - wr_chunk + NUM_CHUNKS_DEF) % NUM_CHUNKS_DEF)
			* CHUNK_LEN_DEF * 4);
		r.underruns = underruns;
		r.played    = played;
		return r;
	endfunction

	task automatic ring_advance(input logic op_i, input frame_t f);
		int k;
		if (op_i == OP_WRITE) begin
			if (wr_chunk == q_chunk || wr_chunk == play_chunk) begin
				ring_outputs_due.push_back(ring_status(1'b0, '0, 1'b1));
			end else begin
				ring_mem[wr_chunk][wr_off] = {f[FRAME_W/2-1:0], f[FRAME_W-1:FRAME_W/2]};
				wr_off++;
				if (wr_off == CHUNK_LEN_DEF) begin
					wr_off   = 0;
					wr_chunk = (wr_chunk + 1) % NUM_CHUNKS_DEF;
				end
				ring_outputs_due.push_back(ring_status(1'b1, '0, 1'b1));
			end
		end else begin
			for (k = 0; k < CHUNK_LEN_DEF; k++)
				ring_mem[play_chunk][k] = '0;
			play_chunk = q_chunk;
			q_chunk    = (q_chunk + 1) % NUM_CHUNKS_DEF;
			if (q_chunk == wr_chunk)
				underruns = underruns + 1'b1;
			played = played + COUNT_W'(CHUNK_LEN_DEF);
			for (k = 0; k < CHUNK_LEN_DEF; k++)
				ring_outputs_due.push_back(ring_status(1'b0, ring_mem[q_chunk][k],
					k == CHUNK_LEN_DEF - 1));
		end
	endtask

	task automatic queue_item(input logic o, input frame_t f);
		host_item_t it;
		it.op    = o;
		it.frame = f;
		host_items.push_back(it);
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// input transactions feed the predictor; result transactions are checked in order
	always @(posedge clk) begin
		item_taken <= item_valid && !item_stall;
		if (arst_n) begin
			if (item_valid && !item_stall)
				ring_advance(op, frame_in);
			if (result_valid && !result_stall) begin
				if (ring_outputs_due.size() == 0) begin
					$error("result transaction with nothing outstanding");
					errors++;
				end else begin
					want = ring_outputs_due.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("frame_out", want.frame, frame_out);
					check_field("last", want.last_beat, last);
					check_field("queued_chunk", want.queued, queued_chunk);
					check_field("free_bytes", want.free, free_bytes);
					check_field("underrun_count", want.underruns, underrun_count);
					check_field("frames_played", want.played, frames_played);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			steady <= sent >= QUIET_LO && sent < QUIET_HI;
			if (host_items.size() == 0
					|| (sent == SETTLE_AT && ring_outputs_due.size() != 0)
					|| (!steady && $urandom_range(99) < IDLE_PCT)) begin
				item_valid <= 1'b0;
			end else begin
				next_item = host_items.pop_front();
				item_valid <= 1'b1;
				op         <= next_item.op;
				frame_in   <= next_item.frame;
				sent       <= sent + 1;
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (!hold_done && sent == HOLD_AT) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int n;
		int j;
		foreach (ring_mem[c, k])
			ring_mem[c][k] = '0;

		// directed: field extremes, readout of written chunk with underrun, ring full
		queue_item(OP_WRITE, 32'h0000_0000);
		queue_item(OP_WRITE, 32'hFFFF_FFFF);
		queue_item(OP_WRITE, 32'h0000_FFFF);
		queue_item(OP_WRITE, 32'hFFFF_0000);
		queue_item(OP_WRITE, 32'h8000_0001);
		queue_item(OP_WRITE, 32'h1234_5678);
		repeat (NUM_CHUNKS_DEF - 1)
			queue_item(OP_DONE, '0);
		queue_item(OP_WRITE, 32'hA5A5_5A5A);
		queue_item(OP_DONE, 32'hFFFF_FFFF);
		queue_item(OP_WRITE, 32'h5A5A_A5A5);

		// random: mostly write bursts followed by a few chunk-done events, some noise
		while (host_items.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if ($urandom_range(99) < 80) begin
				n = $urandom_range(70);
				for (j = 0; j < n; j++)
					queue_item(OP_WRITE, $urandom);
				n = $urandom_range(4, 1);
				for (j = 0; j < n; j++)
					queue_item(OP_DONE, $urandom);
			end else begin
				n = $urandom_range(12, 1);
				for (j = 0; j < n; j++)
					queue_item($urandom_range(1) ? OP_DONE : OP_WRITE, $urandom);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (host_items.size() != 0 || item_valid || ring_outputs_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && ring_outputs_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
